### hdl/crse_pkg.sv
// Shared constants and types for the clock ratio search and encoder.
package crse_pkg;

	localparam int MAX_FACTOR_DEF = 128;
	localparam int FREQ_W         = 11;
	localparam int FREQ_LIMIT     = 1280;
	localparam int FREQ_SCALE     = 1000;
	localparam int RATIO_DEN      = 10000;
	localparam int T_W            = 21;
	localparam int FACTOR_W       = 9;
	localparam int DIFF_W         = 29;
	localparam int CM_W           = 22;
	localparam int PROD_W         = FACTOR_W + DIFF_W;
	localparam int CELL_COUNT     = 4;
	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 16;
	localparam int OUT_F_W        = 8;

	localparam logic [DATA_W-1:0] DATA_FLAG = 16'h1000;
	localparam logic [DATA_W-1:0] DATA_OUT0 = 16'h1000 | (16'd5 << 6) | 16'd5;
	localparam logic [DATA_W-1:0] DATA_OUT1 = 16'h1000 | (16'd1 << 6) | 16'd1;

	localparam logic [ADDR_W-1:0] ADDR_MULT = 5'h14;
	localparam logic [ADDR_W-1:0] ADDR_DIV  = 5'h16;
	localparam logic [ADDR_W-1:0] ADDR_OUT0 = 5'h08;
	localparam logic [ADDR_W-1:0] ADDR_OUT1 = 5'h0A;

	typedef enum logic [1:0] {CELL_IDLE, CELL_RUN, CELL_FLUSH, CELL_DONE} cell_state_t;
	typedef enum logic [1:0] {WR_MULT, WR_DIV, WR_OUT0, WR_OUT1} wr_sel_t;

	typedef struct packed {
		logic [T_W-1:0]      t;
		logic                have;
		logic [FACTOR_W-1:0] bm;
		logic [FACTOR_W-1:0] bd;
		logic [DIFF_W-1:0]   bdiff;
	} search_t;

endpackage

### hdl/crse_cell.sv
// Search cell: tries multipliers 2..MAX_FACTOR on its divider slice, passes the best on.
module crse_cell #(
	parameter int MAX_FACTOR = crse_pkg::MAX_FACTOR_DEF,
	parameter int D_LO       = 1,
	parameter int D_HI       = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crse_pkg::search_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output crse_pkg::search_t out_item
);

	localparam int FW = crse_pkg::FACTOR_W;
	localparam int XW = crse_pkg::DIFF_W;
	localparam int PW = crse_pkg::PROD_W;
	localparam int CW = crse_pkg::CM_W;
	localparam logic [FW-1:0] M_FIRST  = FW'(2);
	localparam logic [FW-1:0] M_LAST   = FW'(MAX_FACTOR);
	localparam logic [FW-1:0] D_FIRST  = FW'(D_LO);
	localparam logic [FW-1:0] D_LAST   = FW'(D_HI);
	localparam logic [CW-1:0] CM_FIRST = CW'(2 * crse_pkg::RATIO_DEN);
	localparam logic [CW-1:0] CM_STEP  = CW'(crse_pkg::RATIO_DEN);
	localparam bit EMPTY = (D_LO > D_HI);

	crse_pkg::cell_state_t state_q, state_d;
	crse_pkg::search_t     item_q;
	logic [FW-1:0] m_q, d_q;
	logic [CW-1:0] cm_q;
	logic [XW-1:0] dt_q;
	logic          v_s1;
	logic [XW-1:0] x_s1;
	logic [FW-1:0] m_s1, d_s1;
	logic          gen_valid, gen_last, take;
	logic [XW-1:0] cmx, x_d;
	logic [PW-1:0] cur, tst;

	assign gen_valid = (state_q == crse_pkg::CELL_RUN);
	assign gen_last  = (m_q == M_LAST) && (d_q == D_LAST);
	assign in_ready  = (state_q == crse_pkg::CELL_IDLE);
	assign out_valid = (state_q == crse_pkg::CELL_DONE);
	assign out_item  = item_q;

	assign cmx = XW'(cm_q);
	assign x_d = (cmx >= dt_q) ? (cmx - dt_q) : (dt_q - cmx);
	assign cur = PW'(d_s1) * PW'(item_q.bdiff);
	assign tst = PW'(item_q.bd) * PW'(x_s1);
	assign take = !item_q.have || (tst < cur);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crse_pkg::CELL_IDLE: begin
				if (in_valid) begin
					if (EMPTY) state_d = crse_pkg::CELL_DONE;
					else state_d = crse_pkg::CELL_RUN;
				end
			end
			crse_pkg::CELL_RUN: begin
				if (gen_last) state_d = crse_pkg::CELL_FLUSH;
			end
			crse_pkg::CELL_FLUSH: state_d = crse_pkg::CELL_DONE;
			crse_pkg::CELL_DONE: begin
				if (out_ready) state_d = crse_pkg::CELL_IDLE;
			end
			default: state_d = crse_pkg::CELL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crse_pkg::CELL_IDLE;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= gen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= in_item;
			m_q    <= M_FIRST;
			d_q    <= D_FIRST;
			cm_q   <= CM_FIRST;
			dt_q   <= XW'(D_LO) * XW'(in_item.t);
		end else begin
			if (gen_valid) begin
				if (m_q == M_LAST) begin
					m_q  <= M_FIRST;
					cm_q <= CM_FIRST;
					d_q  <= d_q + FW'(1);
					dt_q <= dt_q + XW'(item_q.t);
				end else begin
					m_q  <= m_q + FW'(1);
					cm_q <= cm_q + CM_STEP;
				end
			end
			if (v_s1 && take) begin
				item_q.have  <= 1'b1;
				item_q.bm    <= m_s1;
				item_q.bd    <= d_s1;
				item_q.bdiff <= x_s1;
			end
		end
		x_s1 <= x_d;
		m_s1 <= m_q;
		d_s1 <= d_q;
	end

	a_flush_has_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crse_pkg::CELL_FLUSH) |-> v_s1)
		else $error("flush without pending candidate");
	a_cand_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == crse_pkg::CELL_RUN))
		else $error("candidate outside search");
	a_done_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crse_pkg::CELL_DONE && !EMPTY) |-> item_q.have)
		else $error("search finished without best");
	a_best_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crse_pkg::CELL_DONE && item_q.have) |->
		(item_q.bd >= FW'(1) && item_q.bd <= D_LAST))
		else $error("best divider out of range");

endmodule

### hdl/crse_emit.sv
// Register write encoder: turns one search result into four synthesizer writes.
module crse_emit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  crse_pkg::search_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [crse_pkg::ADDR_W-1:0]         reg_address,
	output logic [crse_pkg::DATA_W-1:0]         reg_data,
	output logic [crse_pkg::OUT_F_W-1:0]        chosen_mult,
	output logic [crse_pkg::OUT_F_W-1:0]        chosen_div,
	output logic                                last_write
);

	localparam int FW = crse_pkg::FACTOR_W;

	function automatic logic [crse_pkg::DATA_W-1:0] split_count(input logic [FW-1:0] c);
		logic [7:0] half;
		logic [7:0] low;
		half = c[8:1];
		low  = half + {7'b0, c[0]};
		split_count = {2'b00, half, 6'b000000} | {8'h00, low};
	endfunction

	logic                  valid_q;
	crse_pkg::wr_sel_t     sel_q;
	logic [FW-1:0]         mult_q, div_q;
	logic                  xfer;

	assign xfer      = valid_q && !out_stall;
	assign in_ready  = !valid_q || (xfer && sel_q == crse_pkg::WR_OUT1);
	assign out_valid = valid_q;
	assign chosen_mult = mult_q[crse_pkg::OUT_F_W-1:0];
	assign chosen_div  = div_q[crse_pkg::OUT_F_W-1:0];
	assign last_write  = (sel_q == crse_pkg::WR_OUT1);

	always_comb begin
		unique case (sel_q)
			crse_pkg::WR_MULT: begin
				reg_address = crse_pkg::ADDR_MULT;
				reg_data    = crse_pkg::DATA_FLAG | split_count(mult_q);
			end
			crse_pkg::WR_DIV: begin
				reg_address = crse_pkg::ADDR_DIV;
				reg_data    = (div_q == FW'(1)) ? crse_pkg::DATA_FLAG : split_count(div_q);
			end
			crse_pkg::WR_OUT0: begin
				reg_address = crse_pkg::ADDR_OUT0;
				reg_data    = crse_pkg::DATA_OUT0;
			end
			default: begin
				reg_address = crse_pkg::ADDR_OUT1;
				reg_data    = crse_pkg::DATA_OUT1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= crse_pkg::WR_MULT;
		end else if (in_ready && in_valid) begin
			valid_q <= 1'b1;
			sel_q   <= crse_pkg::WR_MULT;
		end else if (xfer) begin
			unique case (sel_q)
				crse_pkg::WR_MULT: sel_q <= crse_pkg::WR_DIV;
				crse_pkg::WR_DIV:  sel_q <= crse_pkg::WR_OUT0;
				crse_pkg::WR_OUT0: sel_q <= crse_pkg::WR_OUT1;
				default: begin
					sel_q   <= crse_pkg::WR_MULT;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mult_q <= in_item.bm;
			div_q  <= in_item.bd;
		end
	end

endmodule

### hdl/clock_ratio_search_and_encode.sv
// Top level: chain of ratio search cells followed by the register write encoder.
// Each request runs through CELL_COUNT search cells; a cell owns an equal slice of the
// dividers and tests one multiplier/divider candidate per cycle; it holds an item while
// it runs through its slice, flushes the last candidate and waits in its done state until
// the next stage takes the result, then returns to idle before it takes the next one.
// The cells work on different requests at once, so a new request can enter the first
// cell while later cells still search earlier ones; the four write transfers then leave
// at up to one per cycle while out_stall is low.
module clock_ratio_search_and_encode #(
	parameter int MAX_FACTOR = crse_pkg::MAX_FACTOR_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [crse_pkg::FREQ_W-1:0]     freq_request,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [crse_pkg::ADDR_W-1:0]     reg_address,
	output logic [crse_pkg::DATA_W-1:0]     reg_data,
	output logic [crse_pkg::OUT_F_W-1:0]    chosen_mult,
	output logic [crse_pkg::OUT_F_W-1:0]    chosen_div,
	output logic                            last_write
);

	localparam int NC = crse_pkg::CELL_COUNT;
	localparam logic [crse_pkg::FREQ_W-1:0] F_LIMIT = crse_pkg::FREQ_W'(crse_pkg::FREQ_LIMIT);

	logic                  c_valid [NC+1];
	logic                  c_ready [NC+1];
	crse_pkg::search_t     c_item  [NC+1];
	crse_pkg::search_t     req_item;
	logic [crse_pkg::FREQ_W-1:0] f_sat;

	assign f_sat = (freq_request > F_LIMIT) ? F_LIMIT : freq_request;

	always_comb begin
		req_item   = '0;
		req_item.t = crse_pkg::T_W'(f_sat) * crse_pkg::T_W'(crse_pkg::FREQ_SCALE);
	end

	assign c_item[0]  = req_item;
	assign c_valid[0] = in_valid;
	assign in_stall   = !c_ready[0];

	for (genvar j = 0; j < NC; j++) begin : g_cell
		crse_cell #(
			.MAX_FACTOR(MAX_FACTOR),
			.D_LO(j * MAX_FACTOR / NC + 1),
			.D_HI((j + 1) * MAX_FACTOR / NC)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (c_valid[j]),
			.in_ready (c_ready[j]),
			.in_item  (c_item[j]),
			.out_valid(c_valid[j+1]),
			.out_ready(c_ready[j+1]),
			.out_item (c_item[j+1])
		);
	end

	crse_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (c_valid[NC]),
		.in_ready   (c_ready[NC]),
		.in_item    (c_item[NC]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.reg_address(reg_address),
		.reg_data   (reg_data),
		.chosen_mult(chosen_mult),
		.chosen_div (chosen_div),
		.last_write (last_write)
	);

endmodule
